// ===== rtl/core/mono_square_frame_buffer_assert.svh =====
// ---------------------------------------------------------------------------
// mono_square_frame_buffer assertion macros
// shared property templates for the frame buffer checker
// ---------------------------------------------------------------------------
`ifndef MONO_SQUARE_FRAME_BUFFER_ASSERT_SVH
`define MONO_SQUARE_FRAME_BUFFER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MSFB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MSFB_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/msfb_pkg.sv =====
// ---------------------------------------------------------------------------
// msfb_pkg
// types and constants shared by the frame buffer controller and datapath
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package msfb_pkg;

    // command codes
    localparam logic [2:0] CMD_DRAW     = 3'd0;
    localparam logic [2:0] CMD_ERASE    = 3'd1;
    localparam logic [2:0] CMD_READ_PIX = 3'd2;
    localparam logic [2:0] CMD_READ_ROW = 3'd3;
    localparam logic [2:0] CMD_READ_COL = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;

    // byte packing
    localparam int PIX_PER_BYTE = 8;
    localparam int TOP_BIT      = 7;

    // side length register
    localparam int         SIDE_REG_W = 7;
    localparam logic [6:0] SIDE_RESET = 7'd64;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] x;
        logic [6:0] y;
    } in_item_t;

    typedef struct packed {
        logic       ok;
        logic       pixel;
        logic [7:0] data_byte;
        logic       last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PIX,
        ST_ROW_LOAD,
        ST_COL_SCAN,
        ST_EMIT,
        ST_FAIL,
        ST_DONE
    } fsm_state_t;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_OK,
        RES_PIXEL,
        RES_BYTE
    } res_kind_t;

    // controller to datapath
    typedef struct packed {
        logic      item_load;
        logic      ram_rd;
        logic      ram_wr;
        logic      addr_scan;
        logic      valid_clr;
        logic      scan_clr;
        logic      line_load;
        logic      col_capture;
        logic      byte_clr;
        logic      out_load;
        res_kind_t res_kind;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] command;
        logic       pix_oob;
        logic       line_oob;
        logic       scan_done;
        logic       rd_pend;
        logic       byte_last;
        logic       out_free;
    } ctrl_status_t;

endpackage

// ===== rtl/core/msfb_ram.sv =====
// ---------------------------------------------------------------------------
// msfb_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msfb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/msfb_ctrl.sv =====
// ---------------------------------------------------------------------------
// msfb_ctrl
// command sequencer for the frame buffer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msfb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  msfb_pkg::ctrl_status_t status,
    output msfb_pkg::ctrl_cmd_t    cmd
);

    import msfb_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = RES_FAIL;
        s_ready    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_DECODE;
                end
            end

            ST_DECODE: begin
                unique case (status.command)
                    CMD_DRAW, CMD_ERASE, CMD_READ_PIX: begin
                        if (status.pix_oob) begin
                            state_next = ST_FAIL;
                        end else begin
                            cmd.ram_rd = 1'b1;
                            state_next = ST_PIX;
                        end
                    end
                    CMD_READ_ROW: begin
                        if (status.line_oob) begin
                            state_next = ST_FAIL;
                        end else begin
                            cmd.ram_rd = 1'b1;
                            state_next = ST_ROW_LOAD;
                        end
                    end
                    CMD_READ_COL: begin
                        if (status.line_oob) begin
                            state_next = ST_FAIL;
                        end else begin
                            cmd.scan_clr = 1'b1;
                            state_next   = ST_COL_SCAN;
                        end
                    end
                    CMD_CLEAR: begin
                        cmd.valid_clr = 1'b1;
                        state_next    = ST_DONE;
                    end
                    default: begin
                        state_next = ST_FAIL;
                    end
                endcase
            end

            // read-modify-write of one row for draw and erase, result in the same cycle
            ST_PIX: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.res_kind = RES_PIXEL;
                    cmd.ram_wr   = (status.command == CMD_DRAW) ||
                                   (status.command == CMD_ERASE);
                    state_next   = ST_IDLE;
                end
            end

            ST_ROW_LOAD: begin
                cmd.line_load = 1'b1;
                cmd.byte_clr  = 1'b1;
                state_next    = ST_EMIT;
            end

            // one row read per cycle, bit captured in the cycle after its read
            ST_COL_SCAN: begin
                cmd.addr_scan   = 1'b1;
                cmd.ram_rd      = !status.scan_done;
                cmd.col_capture = 1'b1;
                if (status.scan_done && !status.rd_pend) begin
                    cmd.byte_clr = 1'b1;
                    state_next   = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.res_kind = RES_BYTE;
                    if (status.byte_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_FAIL: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.res_kind = RES_FAIL;
                    state_next   = ST_IDLE;
                end
            end

            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.res_kind = RES_OK;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/msfb_dp.sv =====
// ---------------------------------------------------------------------------
// msfb_dp
// frame buffer datapath: bitmap rows, row valid bits, line buffer, output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msfb_dp #(
    parameter int MAX_SIDE = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [6:0]             cfg_wdata,
    input  msfb_pkg::in_item_t     s_data,
    input  msfb_pkg::ctrl_cmd_t    cmd,
    output msfb_pkg::ctrl_status_t status,
    input  logic                   m_ready,
    output logic                   m_valid,
    output msfb_pkg::out_item_t    m_data
);

    import msfb_pkg::*;

    localparam int AW   = $clog2(MAX_SIDE);
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int CMPW = (SW > SIDE_REG_W) ? SW : SIDE_REG_W;
    localparam int NB   = (MAX_SIDE + TOP_BIT) / PIX_PER_BYTE;
    localparam int LW   = NB * PIX_PER_BYTE;
    localparam int LIW  = $clog2(LW);
    localparam int BCW  = $clog2(NB + 1);

    logic [6:0]          side_reg;
    in_item_t            item_reg;
    logic [MAX_SIDE-1:0] valid_reg;
    logic                rd_valid_reg;
    logic                rd_pend_reg;
    logic [AW-1:0]       rd_addr_reg;
    logic [SW-1:0]       scan_reg;
    logic [LW-1:0]       line_reg;
    logic [BCW-1:0]      byte_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    out_item_t           m_data_next;

    logic [CMPW-1:0]     eff_side;
    logic [CMPW:0]       nbytes_m1;
    logic [AW-1:0]       x_idx;
    logic [AW-1:0]       y_idx;
    logic [AW-1:0]       addr;
    logic [MAX_SIDE-1:0] rdata;
    logic [MAX_SIDE-1:0] row_word;
    logic [MAX_SIDE-1:0] wr_word;
    logic                out_free;
    logic [LIW-1:0]      byte_base;
    logic [7:0]          line_byte;

    // clamp side to 1..MAX_SIDE
    always_comb begin
        if (side_reg == '0) begin
            eff_side = CMPW'(1);
        end else if (CMPW'(side_reg) > CMPW'(MAX_SIDE)) begin
            eff_side = CMPW'(MAX_SIDE);
        end else begin
            eff_side = CMPW'(side_reg);
        end
    end

    assign x_idx = AW'(item_reg.x);
    assign y_idx = AW'(item_reg.y);
    assign addr  = cmd.addr_scan ? scan_reg[AW-1:0] : y_idx;

    // bytes per line minus one
    assign nbytes_m1 = (((CMPW+1)'(eff_side) + (CMPW+1)'(TOP_BIT)) >> 3) - (CMPW+1)'(1);

    // bitmap rows
    msfb_ram #(
        .WIDTH (MAX_SIDE),
        .DEPTH (MAX_SIDE)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.ram_wr),
        .re    (cmd.ram_rd),
        .addr  (addr),
        .wdata (wr_word),
        .rdata (rdata)
    );

    // rows never written since reset or clear read as zero
    assign row_word = rd_valid_reg ? rdata : '0;

    // single pixel update
    always_comb begin
        wr_word        = row_word;
        wr_word[x_idx] = (item_reg.command == CMD_DRAW);
    end

    // pack current line byte, first pixel in the top bit, beyond side is zero
    assign byte_base = LIW'({byte_reg, 3'b000});
    always_comb begin
        for (int i = 0; i < PIX_PER_BYTE; i++) begin
            line_byte[TOP_BIT-i] = line_reg[byte_base + LIW'(i)] &&
                                   (CMPW'({byte_reg, 3'(i)}) < eff_side);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // result word
    always_comb begin
        m_data_next = '0;
        m_data_next.last = 1'b1;
        unique case (cmd.res_kind)
            RES_FAIL: begin
                m_data_next.ok = 1'b0;
            end
            RES_OK: begin
                m_data_next.ok = 1'b1;
            end
            RES_PIXEL: begin
                m_data_next.ok    = 1'b1;
                m_data_next.pixel = (item_reg.command == CMD_READ_PIX) && row_word[x_idx];
            end
            RES_BYTE: begin
                m_data_next.ok        = 1'b1;
                m_data_next.data_byte = line_byte;
                m_data_next.last      = status.byte_last;
            end
            default: begin
                m_data_next.ok = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg    <= SIDE_RESET;
            valid_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                side_reg <= cfg_wdata;
            end
            if (cmd.valid_clr) begin
                valid_reg <= '0;
            end else if (cmd.ram_wr) begin
                valid_reg[y_idx] <= 1'b1;
            end
            rd_pend_reg <= cmd.ram_rd;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_data;
        end
        if (cmd.ram_rd) begin
            rd_valid_reg <= valid_reg[addr];
            rd_addr_reg  <= addr;
        end
        if (cmd.scan_clr) begin
            scan_reg <= '0;
        end else if (cmd.ram_rd && cmd.addr_scan) begin
            scan_reg <= scan_reg + SW'(1);
        end
        if (cmd.scan_clr) begin
            line_reg <= '0;
        end else if (cmd.line_load) begin
            line_reg <= LW'(row_word);
        end else if (cmd.col_capture && rd_pend_reg) begin
            line_reg[LIW'(rd_addr_reg)] <= row_word[y_idx];
        end
        if (cmd.byte_clr) begin
            byte_reg <= '0;
        end else if (cmd.out_load && (cmd.res_kind == RES_BYTE)) begin
            byte_reg <= byte_reg + BCW'(1);
        end
        if (cmd.out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    // status to the controller
    always_comb begin
        status           = '0;
        status.command   = item_reg.command;
        status.pix_oob   = (CMPW'(item_reg.x) >= eff_side) || (CMPW'(item_reg.y) >= eff_side);
        status.line_oob  = (CMPW'(item_reg.y) >= eff_side);
        status.scan_done = (CMPW'(scan_reg) == eff_side);
        status.rd_pend   = rd_pend_reg;
        status.byte_last = ((CMPW+1)'(byte_reg) == nbytes_m1);
        status.out_free  = out_free;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/mono_square_frame_buffer.sv =====
// ---------------------------------------------------------------------------
// mono_square_frame_buffer
// square one-bit-per-pixel frame buffer with pixel, line and clear commands
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  cfg       in         cfg_we (no wait)     cfg_wdata: side length
//  s_        in         s_valid / s_ready    in_item_t: command, x, y
//  m_        out        m_valid / m_ready    out_item_t: ok, pixel, data_byte, last
//
// one request at a time; the bitmap is a single-port ram of MAX_SIDE rows.
// pixel commands step through accept, decode, and write back with result.
// row read loads the row and then emits ceil(side/8) bytes; column read reads one row per
// cycle, then emits its bytes the same way; clear and rejects go straight to a result.
// reset and clear drop per-row valid bits at once, so there is no sweep.
// a stalled result holds in the output register and delays the next byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mono_square_frame_buffer #(
    parameter int MAX_SIDE = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  msfb_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output msfb_pkg::out_item_t m_data
);

    import msfb_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // sequencer
    msfb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // storage and result path
    msfb_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/core/msfb_checker.sv =====
// ---------------------------------------------------------------------------
// msfb_checker
// port-level checks for the frame buffer, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mono_square_frame_buffer_assert.svh"

module msfb_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input msfb_pkg::out_item_t m_data
);

    import msfb_pkg::*;

    // held result stays put
    `MSFB_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // one request in flight: no accept right after an accept
    `MSFB_ASSERT_NXT(a_one_req, aclk, aresetn, s_valid && s_ready, !s_ready, "request accepted while busy")

    // a reject is a lone, empty, final result
    `MSFB_ASSERT_IMP(a_reject, aclk, aresetn, m_valid && !m_data.ok, m_data.last && !m_data.pixel && (m_data.data_byte == 8'd0), "malformed reject")

    // a pixel value never comes with line data
    `MSFB_ASSERT_IMP(a_pixel, aclk, aresetn, m_valid && m_data.pixel, m_data.ok && m_data.last && (m_data.data_byte == 8'd0), "pixel result mixed with line data")

endmodule

bind mono_square_frame_buffer msfb_checker u_msfb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
